// ===== src/ssi_pkg.sv =====
// ----------------------------------------------------------------------------
// Segment intersection package
// Shared control type and configuration register indexes.
// ----------------------------------------------------------------------------
package ssi_pkg;

    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MIRROR_START_X = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MIRROR_START_Y = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MIRROR_END_X   = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MIRROR_END_Y   = 2'd3;

    typedef struct packed {
        logic valid;
        logic hit;
        logic neg_x;
        logic neg_y;
    } t_div_ctrl;

endpackage

// ===== src/segment_segment_intersection_top.sv =====
// ----------------------------------------------------------------------------
// Segment intersection top level
// Tests each incoming segment against the configured mirror segment and
// returns the hit flag and the crossing point.
//
// The input channel (i_in_valid, o_in_ready) carries the two endpoints of a
// tested segment; the output channel (o_out_valid, i_out_ready) returns one
// result per transfer, in order. The mirror endpoints are written through
// i_cfg_we, i_cfg_index and i_cfg_data only while the block is idle; the user
// must keep to that, as the block does not enforce it. The pipeline has four
// front stages, one divider stage per direction bit, and the output register.
// Throughput, set by the fully pipelined datapath, is one transfer per cycle
// unless the receiver stalls. When it stalls, the pipeline holds as a whole
// unless its last stage is empty, so a waiting result still lets new transfers
// in. Reset clears all valid bits and sets the mirror registers to zero.
// ----------------------------------------------------------------------------
module segment_segment_intersection_top #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ssi_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [COORD_WIDTH-1:0]              i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [COORD_WIDTH-1:0]              i_ray_start_x,
    input  logic [COORD_WIDTH-1:0]              i_ray_start_y,
    input  logic [COORD_WIDTH-1:0]              i_ray_end_x,
    input  logic [COORD_WIDTH-1:0]              i_ray_end_y,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_hit,
    output logic [COORD_WIDTH-1:0]              o_cross_x,
    output logic [COORD_WIDTH-1:0]              o_cross_y
);
    import ssi_pkg::*;

    localparam int W = COORD_WIDTH;
    localparam int D = 2 * COORD_WIDTH + 2;
    localparam int R = D + 1;

    logic [W-1:0] r_mirror_start_x, r_mirror_start_y, r_mirror_end_x, r_mirror_end_y;

    t_div_ctrl    w_ctrl      [0:W];
    logic [R-1:0] w_rem_x     [0:W];
    logic [R-1:0] w_rem_y     [0:W];
    logic [W-1:0] w_quo_x     [0:W];
    logic [W-1:0] w_quo_y     [0:W];
    logic [D-1:0] w_t_mag     [0:W];
    logic [D-1:0] w_den_mag   [0:W];
    logic [W-1:0] w_dir_x_mag [0:W];
    logic [W-1:0] w_dir_y_mag [0:W];
    logic [W-1:0] w_start_x   [0:W];
    logic [W-1:0] w_start_y   [0:W];

    logic         w_out_free, w_en;
    logic         r_out_valid, r_hit;
    logic [W-1:0] r_cross_x, r_cross_y;
    logic [W-1:0] n_cross_x, n_cross_y, n_off_x, n_off_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mirror_start_x <= '0;
            r_mirror_start_y <= '0;
            r_mirror_end_x   <= '0;
            r_mirror_end_y   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MIRROR_START_X: r_mirror_start_x <= i_cfg_data;
                CFG_MIRROR_START_Y: r_mirror_start_y <= i_cfg_data;
                CFG_MIRROR_END_X:   r_mirror_end_x   <= i_cfg_data;
                CFG_MIRROR_END_Y:   r_mirror_end_y   <= i_cfg_data;
            endcase
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_en       = w_out_free || !w_ctrl[W].valid;
    assign o_in_ready = w_en;

    ssi_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (w_en),
        .i_valid         (i_in_valid),
        .i_mirror_start_x(r_mirror_start_x),
        .i_mirror_start_y(r_mirror_start_y),
        .i_mirror_end_x  (r_mirror_end_x),
        .i_mirror_end_y  (r_mirror_end_y),
        .i_ray_start_x   (i_ray_start_x),
        .i_ray_start_y   (i_ray_start_y),
        .i_ray_end_x     (i_ray_end_x),
        .i_ray_end_y     (i_ray_end_y),
        .o_ctrl          (w_ctrl[0]),
        .o_t_mag         (w_t_mag[0]),
        .o_den_mag       (w_den_mag[0]),
        .o_dir_x_mag     (w_dir_x_mag[0]),
        .o_dir_y_mag     (w_dir_y_mag[0]),
        .o_start_x       (w_start_x[0]),
        .o_start_y       (w_start_y[0])
    );

    assign w_rem_x[0] = '0;
    assign w_rem_y[0] = '0;
    assign w_quo_x[0] = '0;
    assign w_quo_y[0] = '0;

    for (genvar k = 0; k < W; k++) begin : g_div
        ssi_div_step #(
            .COORD_WIDTH(COORD_WIDTH),
            .STEP       (k)
        ) u_step (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (w_en),
            .i_ctrl     (w_ctrl[k]),
            .i_rem_x    (w_rem_x[k]),
            .i_rem_y    (w_rem_y[k]),
            .i_quo_x    (w_quo_x[k]),
            .i_quo_y    (w_quo_y[k]),
            .i_t_mag    (w_t_mag[k]),
            .i_den_mag  (w_den_mag[k]),
            .i_dir_x_mag(w_dir_x_mag[k]),
            .i_dir_y_mag(w_dir_y_mag[k]),
            .i_start_x  (w_start_x[k]),
            .i_start_y  (w_start_y[k]),
            .o_ctrl     (w_ctrl[k+1]),
            .o_rem_x    (w_rem_x[k+1]),
            .o_rem_y    (w_rem_y[k+1]),
            .o_quo_x    (w_quo_x[k+1]),
            .o_quo_y    (w_quo_y[k+1]),
            .o_t_mag    (w_t_mag[k+1]),
            .o_den_mag  (w_den_mag[k+1]),
            .o_dir_x_mag(w_dir_x_mag[k+1]),
            .o_dir_y_mag(w_dir_y_mag[k+1]),
            .o_start_x  (w_start_x[k+1]),
            .o_start_y  (w_start_y[k+1])
        );
    end

    always_comb begin
        n_off_x   = w_ctrl[W].neg_x ? -w_quo_x[W] : w_quo_x[W];
        n_off_y   = w_ctrl[W].neg_y ? -w_quo_y[W] : w_quo_y[W];
        n_cross_x = w_ctrl[W].hit ? w_start_x[W] + n_off_x : '0;
        n_cross_y = w_ctrl[W].hit ? w_start_y[W] + n_off_y : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_ctrl[W].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_hit     <= w_ctrl[W].hit;
            r_cross_x <= n_cross_x;
            r_cross_y <= n_cross_y;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_hit;
    assign o_cross_x   = r_cross_x;
    assign o_cross_y   = r_cross_y;

endmodule

// ===== src/ssi_front.sv =====
// ----------------------------------------------------------------------------
// Segment intersection front end
// Four stages: direction differences, cross products, numerators and
// denominator, then the inclusive range tests and magnitudes for the divider.
// ----------------------------------------------------------------------------
module ssi_front #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [COORD_WIDTH-1:0]        i_mirror_start_x,
    input  logic [COORD_WIDTH-1:0]        i_mirror_start_y,
    input  logic [COORD_WIDTH-1:0]        i_mirror_end_x,
    input  logic [COORD_WIDTH-1:0]        i_mirror_end_y,
    input  logic [COORD_WIDTH-1:0]        i_ray_start_x,
    input  logic [COORD_WIDTH-1:0]        i_ray_start_y,
    input  logic [COORD_WIDTH-1:0]        i_ray_end_x,
    input  logic [COORD_WIDTH-1:0]        i_ray_end_y,
    output ssi_pkg::t_div_ctrl            o_ctrl,
    output logic [2*COORD_WIDTH+1:0]      o_t_mag,
    output logic [2*COORD_WIDTH+1:0]      o_den_mag,
    output logic [COORD_WIDTH-1:0]        o_dir_x_mag,
    output logic [COORD_WIDTH-1:0]        o_dir_y_mag,
    output logic [COORD_WIDTH-1:0]        o_start_x,
    output logic [COORD_WIDTH-1:0]        o_start_y
);
    import ssi_pkg::*;

    localparam int W = COORD_WIDTH;
    localparam int D = 2 * COORD_WIDTH + 2;

    logic                 r_v1, r_v2, r_v3;
    t_div_ctrl            r_ctrl;

    logic signed [W:0]    r1_s1x, r1_s1y, r1_s2x, r1_s2y, r1_dx, r1_dy;
    logic [W-1:0]         r1_mx, r1_my;

    logic signed [D-1:0]  r2_den_a, r2_den_b, r2_s_a, r2_s_b, r2_t_a, r2_t_b;
    logic signed [W:0]    r2_s1x, r2_s1y;
    logic [W-1:0]         r2_mx, r2_my;

    logic signed [D-1:0]  r3_den, r3_s, r3_t;
    logic signed [W:0]    r3_s1x, r3_s1y;
    logic [W-1:0]         r3_mx, r3_my;

    logic [D-1:0]         r4_t_mag, r4_den_mag;
    logic [W-1:0]         r4_dir_x_mag, r4_dir_y_mag, r4_mx, r4_my;

    logic [D-1:0]         n_den_mag, n_s_mag, n_t_mag;
    logic [W:0]           n_dir_x_abs, n_dir_y_abs;
    logic                 n_den_neg, n_s_neg, n_t_neg;
    logic                 n_s_in, n_t_in;
    t_div_ctrl            n_ctrl;

    always_comb begin
        n_den_neg   = r3_den[D-1];
        n_s_neg     = r3_s[D-1];
        n_t_neg     = r3_t[D-1];
        n_den_mag   = n_den_neg ? -r3_den : r3_den;
        n_s_mag     = n_s_neg ? -r3_s : r3_s;
        n_t_mag     = n_t_neg ? -r3_t : r3_t;
        n_dir_x_abs = r3_s1x[W] ? -r3_s1x : r3_s1x;
        n_dir_y_abs = r3_s1y[W] ? -r3_s1y : r3_s1y;
        n_s_in      = (r3_s == '0) || ((n_s_neg == n_den_neg) && (n_s_mag <= n_den_mag));
        n_t_in      = (r3_t == '0) || ((n_t_neg == n_den_neg) && (n_t_mag <= n_den_mag));
        n_ctrl.valid = r_v3;
        n_ctrl.hit   = (r3_den != '0) && n_s_in && n_t_in;
        n_ctrl.neg_x = (n_t_neg != n_den_neg) != r3_s1x[W];
        n_ctrl.neg_y = (n_t_neg != n_den_neg) != r3_s1y[W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_ctrl <= '0;
        end else if (i_en) begin
            r_v1   <= i_valid;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_ctrl <= n_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_s1x <= {i_mirror_end_x[W-1], i_mirror_end_x}
                      - {i_mirror_start_x[W-1], i_mirror_start_x};
            r1_s1y <= {i_mirror_end_y[W-1], i_mirror_end_y}
                      - {i_mirror_start_y[W-1], i_mirror_start_y};
            r1_s2x <= {i_ray_end_x[W-1], i_ray_end_x} - {i_ray_start_x[W-1], i_ray_start_x};
            r1_s2y <= {i_ray_end_y[W-1], i_ray_end_y} - {i_ray_start_y[W-1], i_ray_start_y};
            r1_dx  <= {i_mirror_start_x[W-1], i_mirror_start_x}
                      - {i_ray_start_x[W-1], i_ray_start_x};
            r1_dy  <= {i_mirror_start_y[W-1], i_mirror_start_y}
                      - {i_ray_start_y[W-1], i_ray_start_y};
            r1_mx  <= i_mirror_start_x;
            r1_my  <= i_mirror_start_y;

            r2_den_a <= r1_s1x * r1_s2y;
            r2_den_b <= r1_s2x * r1_s1y;
            r2_s_a   <= r1_s1x * r1_dy;
            r2_s_b   <= r1_s1y * r1_dx;
            r2_t_a   <= r1_s2x * r1_dy;
            r2_t_b   <= r1_s2y * r1_dx;
            r2_s1x   <= r1_s1x;
            r2_s1y   <= r1_s1y;
            r2_mx    <= r1_mx;
            r2_my    <= r1_my;

            r3_den <= r2_den_a - r2_den_b;
            r3_s   <= r2_s_a - r2_s_b;
            r3_t   <= r2_t_a - r2_t_b;
            r3_s1x <= r2_s1x;
            r3_s1y <= r2_s1y;
            r3_mx  <= r2_mx;
            r3_my  <= r2_my;

            r4_t_mag     <= n_t_mag;
            r4_den_mag   <= n_den_mag;
            r4_dir_x_mag <= n_dir_x_abs[W-1:0];
            r4_dir_y_mag <= n_dir_y_abs[W-1:0];
            r4_mx        <= r3_mx;
            r4_my        <= r3_my;
        end
    end

    assign o_ctrl      = r_ctrl;
    assign o_t_mag     = r4_t_mag;
    assign o_den_mag   = r4_den_mag;
    assign o_dir_x_mag = r4_dir_x_mag;
    assign o_dir_y_mag = r4_dir_y_mag;
    assign o_start_x   = r4_mx;
    assign o_start_y   = r4_my;

endmodule

// ===== src/ssi_div_step.sv =====
// ----------------------------------------------------------------------------
// Segment intersection divider step
// One stage of the combined multiply and divide: takes one bit of each
// direction magnitude, adds the numerator, and retires a radix-2 digit of
// value 0, 1 or 2 for both axes.
// ----------------------------------------------------------------------------
module ssi_div_step #(
    parameter int COORD_WIDTH = 16,
    parameter int STEP        = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  ssi_pkg::t_div_ctrl            i_ctrl,
    input  logic [2*COORD_WIDTH+2:0]      i_rem_x,
    input  logic [2*COORD_WIDTH+2:0]      i_rem_y,
    input  logic [COORD_WIDTH-1:0]        i_quo_x,
    input  logic [COORD_WIDTH-1:0]        i_quo_y,
    input  logic [2*COORD_WIDTH+1:0]      i_t_mag,
    input  logic [2*COORD_WIDTH+1:0]      i_den_mag,
    input  logic [COORD_WIDTH-1:0]        i_dir_x_mag,
    input  logic [COORD_WIDTH-1:0]        i_dir_y_mag,
    input  logic [COORD_WIDTH-1:0]        i_start_x,
    input  logic [COORD_WIDTH-1:0]        i_start_y,
    output ssi_pkg::t_div_ctrl            o_ctrl,
    output logic [2*COORD_WIDTH+2:0]      o_rem_x,
    output logic [2*COORD_WIDTH+2:0]      o_rem_y,
    output logic [COORD_WIDTH-1:0]        o_quo_x,
    output logic [COORD_WIDTH-1:0]        o_quo_y,
    output logic [2*COORD_WIDTH+1:0]      o_t_mag,
    output logic [2*COORD_WIDTH+1:0]      o_den_mag,
    output logic [COORD_WIDTH-1:0]        o_dir_x_mag,
    output logic [COORD_WIDTH-1:0]        o_dir_y_mag,
    output logic [COORD_WIDTH-1:0]        o_start_x,
    output logic [COORD_WIDTH-1:0]        o_start_y
);
    import ssi_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int D    = 2 * COORD_WIDTH + 2;
    localparam int R    = D + 1;
    localparam int BPOS = COORD_WIDTH - 1 - STEP;

    function automatic logic [R+1:0] div_digit(
        input logic [R-1:0] rem,
        input logic [D-1:0] tm,
        input logic [D-1:0] dm,
        input logic         b
    );
        logic [R-1:0] sum;
        logic [R-1:0] d1;
        logic [R-1:0] d2;
        sum = {rem[R-2:0], 1'b0} + (b ? {1'b0, tm} : {R{1'b0}});
        d1  = {1'b0, dm};
        d2  = {dm, 1'b0};
        priority if (sum >= d2) begin
            return {2'd2, sum - d2};
        end else if (sum >= d1) begin
            return {2'd1, sum - d1};
        end else begin
            return {2'd0, sum};
        end
    endfunction

    t_div_ctrl    r_ctrl;
    logic [R-1:0] r_rem_x, r_rem_y;
    logic [W-1:0] r_quo_x, r_quo_y;
    logic [D-1:0] r_t_mag, r_den_mag;
    logic [W-1:0] r_dir_x_mag, r_dir_y_mag, r_start_x, r_start_y;

    logic [R+1:0] n_step_x, n_step_y;
    logic [W-1:0] n_quo_x, n_quo_y;

    always_comb begin
        n_step_x = div_digit(i_rem_x, i_t_mag, i_den_mag, i_dir_x_mag[BPOS]);
        n_step_y = div_digit(i_rem_y, i_t_mag, i_den_mag, i_dir_y_mag[BPOS]);
        n_quo_x  = {i_quo_x[W-2:0], 1'b0} + {{(W-2){1'b0}}, n_step_x[R+1:R]};
        n_quo_y  = {i_quo_y[W-2:0], 1'b0} + {{(W-2){1'b0}}, n_step_y[R+1:R]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_en) begin
            r_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem_x     <= n_step_x[R-1:0];
            r_rem_y     <= n_step_y[R-1:0];
            r_quo_x     <= n_quo_x;
            r_quo_y     <= n_quo_y;
            r_t_mag     <= i_t_mag;
            r_den_mag   <= i_den_mag;
            r_dir_x_mag <= i_dir_x_mag;
            r_dir_y_mag <= i_dir_y_mag;
            r_start_x   <= i_start_x;
            r_start_y   <= i_start_y;
        end
    end

    assign o_ctrl      = r_ctrl;
    assign o_rem_x     = r_rem_x;
    assign o_rem_y     = r_rem_y;
    assign o_quo_x     = r_quo_x;
    assign o_quo_y     = r_quo_y;
    assign o_t_mag     = r_t_mag;
    assign o_den_mag   = r_den_mag;
    assign o_dir_x_mag = r_dir_x_mag;
    assign o_dir_y_mag = r_dir_y_mag;
    assign o_start_x   = r_start_x;
    assign o_start_y   = r_start_y;

endmodule
